// ===== rtl/qrs_pkg.sv =====
// shared constants, result kind codes and queue status type for the quadratic root solver
`timescale 1ns / 1ps
package qrs_pkg;

	localparam int COEF_WIDTH = 16;
	localparam int FRAC_BITS  = 16;
	localparam int OUT_WIDTH  = 33;
	localparam int FIFO_DEPTH = 4;

	localparam logic [1:0] KIND_ERR    = 2'd0;
	localparam logic [1:0] KIND_DOUBLE = 2'd1;
	localparam logic [1:0] KIND_TWO    = 2'd2;
	localparam logic [1:0] KIND_CPLX   = 2'd3;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ===== rtl/qrs_front.sv =====
// front end: takes coefficient beats, forms the discriminant and classifies the roots
`timescale 1ns / 1ps
module qrs_front #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
	parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic signed [COEF_WIDTH-1:0]              coef_a,
	input  logic signed [COEF_WIDTH-1:0]              coef_b,
	input  logic signed [COEF_WIDTH-1:0]              coef_c,
	input  qrs_pkg::fifo_stat_t                       stat,
	output logic                                      push,
	output logic [1:0]                                kind,
	output logic signed [2*COEF_WIDTH+1:0]            disc,
	output logic signed [COEF_WIDTH+FRAC_BITS:0]      nb,
	output logic signed [COEF_WIDTH:0]                den
);

	localparam int DW  = 2 * COEF_WIDTH + 2;
	localparam int NBW = COEF_WIDTH + FRAC_BITS + 1;

	logic                           en;
	logic                           v_s1, v_s2;
	logic signed [COEF_WIDTH-1:0]   a_s1, b_s1, c_s1;
	logic signed [COEF_WIDTH-1:0]   a_s2, b_s2;
	logic signed [2*COEF_WIDTH-1:0] bb_s2, ac_s2;

	assign en       = !v_s2 || !stat.full;
	assign s_tready = en;
	assign push     = v_s2 && !stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef_a;
			b_s1  <= coef_b;
			c_s1  <= coef_c;
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			bb_s2 <= b_s1 * b_s1;
			ac_s2 <= a_s1 * c_s1;
		end
	end

	always_comb begin
		disc = DW'(bb_s2) - (DW'(ac_s2) <<< 2);
		nb   = -(NBW'(b_s2) <<< FRAC_BITS);
		den  = $signed({a_s2, 1'b0});
		if (a_s2 == '0) begin
			kind = qrs_pkg::KIND_ERR;
		end else if (disc == '0) begin
			kind = qrs_pkg::KIND_DOUBLE;
		end else if (disc[DW-1]) begin
			kind = qrs_pkg::KIND_CPLX;
		end else begin
			kind = qrs_pkg::KIND_TWO;
		end
	end

endmodule

// ===== rtl/qrs_fifo.sv =====
// short register queue between the front end and the back end
`timescale 1ns / 1ps
module qrs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = qrs_pkg::FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    wdata,
	input  logic                pop,
	output logic [WIDTH-1:0]    rdata,
	output qrs_pkg::fifo_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      count_q;

	assign stat.full  = (count_q == (AW+1)'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full && !pop |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop) else $error("queue read while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1) else $error("count lost a beat");

endmodule

// ===== rtl/qrs_sqrt_pipe.sv =====
// pipelined restoring integer square root, one root bit per stage
`timescale 1ns / 1ps
module qrs_sqrt_pipe #(
	parameter int RB = 33
) (
	input  logic              clk,
	input  logic              en,
	input  logic [2*RB-1:0]   x_in,
	output logic [RB-1:0]     root
);

	localparam int XW = 2 * RB;

	logic [XW-1:0] x_q    [RB];
	logic [RB+1:0] rem_q  [RB];
	logic [RB-1:0] root_q [RB];

	genvar k;
	for (k = 0; k < RB; k++) begin : g_st
		logic [XW-1:0] xi;
		logic [RB+1:0] ri, rs, tr;
		logic [RB-1:0] qi;
		logic          ge;
		if (k == 0) begin : g_first
			assign xi = x_in;
			assign ri = '0;
			assign qi = '0;
		end else begin : g_next
			assign xi = x_q[k-1];
			assign ri = rem_q[k-1];
			assign qi = root_q[k-1];
		end
		// bring down the next two radicand bits and try root*4+1
		assign rs = {ri[RB-1:0], xi[XW-1 -: 2]};
		assign tr = {qi, 2'b01};
		assign ge = (rs >= tr);
		always_ff @(posedge clk) begin
			if (en) begin
				x_q[k]    <= xi << 2;
				rem_q[k]  <= ge ? rs - tr : rs;
				root_q[k] <= {qi[RB-2:0], ge};
			end
		end
	end

	assign root = root_q[RB-1];

endmodule

// ===== rtl/qrs_div_pipe.sv =====
// pipelined restoring unsigned divider, one quotient bit per stage
`timescale 1ns / 1ps
module qrs_div_pipe #(
	parameter int NW  = 33,
	parameter int DVW = 17
) (
	input  logic            clk,
	input  logic            en,
	input  logic [NW-1:0]   num,
	input  logic [DVW-1:0]  den,
	output logic [NW-1:0]   quo
);

	logic [NW-1:0]  n_q [NW];
	logic [DVW-1:0] d_q [NW];
	logic [DVW-1:0] r_q [NW];
	logic [NW-1:0]  q_q [NW];

	genvar k;
	for (k = 0; k < NW; k++) begin : g_st
		logic [NW-1:0]  ni, qi;
		logic [DVW-1:0] di, ri;
		logic [DVW:0]   rs, rd;
		logic           ge;
		if (k == 0) begin : g_first
			assign ni = num;
			assign di = den;
			assign ri = '0;
			assign qi = '0;
		end else begin : g_next
			assign ni = n_q[k-1];
			assign di = d_q[k-1];
			assign ri = r_q[k-1];
			assign qi = q_q[k-1];
		end
		assign rs = {ri, ni[NW-1]};
		assign ge = (rs >= {1'b0, di});
		assign rd = ge ? rs - {1'b0, di} : rs;
		always_ff @(posedge clk) begin
			if (en) begin
				n_q[k] <= ni << 1;
				d_q[k] <= di;
				r_q[k] <= rd[DVW-1:0];
				q_q[k] <= {qi[NW-2:0], ge};
			end
		end
	end

	assign quo = q_q[NW-1];

endmodule

// ===== rtl/qrs_back.sv =====
// back end: square root, numerators, two dividers, saturation and the output register
`timescale 1ns / 1ps
module qrs_back #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
	parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  qrs_pkg::fifo_stat_t                  stat,
	output logic                                 pop,
	input  logic [1:0]                           kind_in,
	input  logic signed [2*COEF_WIDTH+1:0]       disc_in,
	input  logic signed [COEF_WIDTH+FRAC_BITS:0] nb_in,
	input  logic signed [COEF_WIDTH:0]           den_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           out_kind,
	output logic [qrs_pkg::OUT_WIDTH-1:0]        out_first,
	output logic [qrs_pkg::OUT_WIDTH-1:0]        out_second
);

	localparam int DW  = 2 * COEF_WIDTH + 2;
	localparam int NBW = COEF_WIDTH + FRAC_BITS + 1;
	localparam int RB  = NBW;
	localparam int XW  = 2 * RB;
	localparam int NW  = NBW;
	localparam int DVW = COEF_WIDTH + 1;
	localparam int QW  = NW + 1;
	localparam int OW  = qrs_pkg::OUT_WIDTH;
	localparam int SW  = (QW > OW + 1) ? QW : OW + 1;
	localparam logic signed [SW-1:0] SAT_HI = SW'(34'sh0_FFFF_FFFF);
	localparam logic signed [SW-1:0] SAT_LO = SW'(34'sh3_0000_0000);

	logic en;

	// stage b0: beat taken from the queue
	logic                  v_b0;
	logic [1:0]            kind_b0;
	logic signed [DW-1:0]  disc_b0;
	logic signed [NBW-1:0] nb_b0;
	logic signed [DVW-1:0] den_b0;
	logic [DW-1:0]         mag;
	logic [XW-1:0]         radicand;
	logic [RB-1:0]         root;

	// side lines alongside the root pipe
	logic                  sq_v    [RB];
	logic [1:0]            sq_kind [RB];
	logic signed [NBW-1:0] sq_nb   [RB];
	logic signed [DVW-1:0] sq_den  [RB];

	// numerator stage
	logic                  v_n;
	logic [1:0]            kind_n;
	logic signed [NBW:0]   n1_n, n2_n;
	logic signed [DVW-1:0] den_n;

	// magnitude stage
	logic                  v_a;
	logic [1:0]            kind_a;
	logic [NW-1:0]         n1m_a, n2m_a;
	logic [DVW-1:0]        dm_a;
	logic                  neg1_a, neg2_a;

	logic                  dv_v    [NW];
	logic [1:0]            dv_kind [NW];
	logic                  dv_neg1 [NW];
	logic                  dv_neg2 [NW];
	logic [NW-1:0]         q1m, q2m;

	logic signed [QW-1:0]  q1, q2;
	logic signed [SW-1:0]  q1x, q2x, s1, s2;

	assign en  = !out_valid || out_ready;
	assign pop = en && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b0      <= 1'b0;
			v_n       <= 1'b0;
			v_a       <= 1'b0;
			out_valid <= 1'b0;
			for (int k = 0; k < RB; k++) begin
				sq_v[k] <= 1'b0;
			end
			for (int k = 0; k < NW; k++) begin
				dv_v[k] <= 1'b0;
			end
		end else if (en) begin
			v_b0    <= !stat.empty;
			sq_v[0] <= v_b0;
			for (int k = 1; k < RB; k++) begin
				sq_v[k] <= sq_v[k-1];
			end
			v_n     <= sq_v[RB-1];
			v_a     <= v_n;
			dv_v[0] <= v_a;
			for (int k = 1; k < NW; k++) begin
				dv_v[k] <= dv_v[k-1];
			end
			out_valid <= dv_v[NW-1];
		end
	end

	assign mag      = disc_b0[DW-1] ? DW'(-disc_b0) : DW'(disc_b0);
	assign radicand = XW'(mag) << (2 * FRAC_BITS);

	qrs_sqrt_pipe #(.RB(RB)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.x_in (radicand),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			kind_b0 <= kind_in;
			disc_b0 <= disc_in;
			nb_b0   <= nb_in;
			den_b0  <= den_in;

			sq_kind[0] <= kind_b0;
			sq_nb[0]   <= nb_b0;
			sq_den[0]  <= den_b0;
			for (int k = 1; k < RB; k++) begin
				sq_kind[k] <= sq_kind[k-1];
				sq_nb[k]   <= sq_nb[k-1];
				sq_den[k]  <= sq_den[k-1];
			end

			// a double root has a zero root term, so nb +/- r covers it
			kind_n <= sq_kind[RB-1];
			den_n  <= sq_den[RB-1];
			if (sq_kind[RB-1] == qrs_pkg::KIND_CPLX) begin
				n1_n <= (NBW+1)'(sq_nb[RB-1]);
				n2_n <= $signed({1'b0, root});
			end else begin
				n1_n <= (NBW+1)'(sq_nb[RB-1]) + $signed({1'b0, root});
				n2_n <= (NBW+1)'(sq_nb[RB-1]) - $signed({1'b0, root});
			end

			kind_a <= kind_n;
			n1m_a  <= n1_n[NBW] ? NW'(-n1_n) : NW'(n1_n);
			n2m_a  <= n2_n[NBW] ? NW'(-n2_n) : NW'(n2_n);
			dm_a   <= den_n[DVW-1] ? DVW'(-den_n) : DVW'(den_n);
			neg1_a <= n1_n[NBW] ^ den_n[DVW-1];
			neg2_a <= n2_n[NBW] ^ den_n[DVW-1];

			dv_kind[0] <= kind_a;
			dv_neg1[0] <= neg1_a;
			dv_neg2[0] <= neg2_a;
			for (int k = 1; k < NW; k++) begin
				dv_kind[k] <= dv_kind[k-1];
				dv_neg1[k] <= dv_neg1[k-1];
				dv_neg2[k] <= dv_neg2[k-1];
			end

			out_kind <= dv_kind[NW-1];
			if (dv_kind[NW-1] == qrs_pkg::KIND_ERR) begin
				out_first  <= '0;
				out_second <= '0;
			end else begin
				out_first  <= s1[OW-1:0];
				out_second <= s2[OW-1:0];
			end
		end
	end

	qrs_div_pipe #(.NW(NW), .DVW(DVW)) u_div1 (
		.clk (clk),
		.en  (en),
		.num (n1m_a),
		.den (dm_a),
		.quo (q1m)
	);

	qrs_div_pipe #(.NW(NW), .DVW(DVW)) u_div2 (
		.clk (clk),
		.en  (en),
		.num (n2m_a),
		.den (dm_a),
		.quo (q2m)
	);

	// restore the sign, truncation toward zero follows from dividing magnitudes
	always_comb begin
		q1  = dv_neg1[NW-1] ? -$signed({1'b0, q1m}) : $signed({1'b0, q1m});
		q2  = dv_neg2[NW-1] ? -$signed({1'b0, q2m}) : $signed({1'b0, q2m});
		q1x = SW'(q1);
		q2x = SW'(q2);
		s1  = (q1x > SAT_HI) ? SAT_HI : ((q1x < SAT_LO) ? SAT_LO : q1x);
		s2  = (q2x > SAT_HI) ? SAT_HI : ((q2x < SAT_LO) ? SAT_LO : q2x);
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == qrs_pkg::KIND_ERR |-> out_first == '0 && out_second == '0)
		else $error("error beat carries nonzero values");
	a_double_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == qrs_pkg::KIND_DOUBLE |-> out_first == out_second)
		else $error("double root values differ");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_first) && $stable(out_kind))
		else $error("stalled result changed");

endmodule

// ===== rtl/quadratic_root_solver_top.sv =====
// top level of the quadratic root solver: front end, queue and back end
`timescale 1ns / 1ps
// Solves a*x^2 + b*x + c = 0 for signed integer coefficients and returns one
// result beat per coefficient beat: the root kind (error for a zero a, double,
// two real, complex pair) and two signed 33-bit fixed-point values with
// FRAC_BITS fraction bits, truncated toward zero and saturated. One beat is
// taken every clock cycle while s_tready is high. Each result passes through
// the bit-per-stage square root followed by the two bit-per-stage dividers
// running side by side; a four-entry queue between the classifying front end
// and the arithmetic back end absorbs output stalls.
module quadratic_root_solver_top #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
	parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// coef_a, coef_b, coef_c, zero fill
	input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]        s_tdata,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// first_value, second_value, zero fill
	output logic [((2*qrs_pkg::OUT_WIDTH+7)/8)*8-1:0] m_tdata,
	// root_kind
	output logic [7:0]                               m_tuser
);

	localparam int W   = COEF_WIDTH;
	localparam int DW  = 2 * W + 2;
	localparam int NBW = W + FRAC_BITS + 1;
	localparam int DVW = W + 1;
	localparam int PW  = 2 + DVW + NBW + DW;
	localparam int OW  = qrs_pkg::OUT_WIDTH;
	localparam int MW  = ((2 * OW + 7) / 8) * 8;

	qrs_pkg::fifo_stat_t   stat;
	logic                  push, pop;
	logic [1:0]            f_kind;
	logic signed [DW-1:0]  f_disc;
	logic signed [NBW-1:0] f_nb;
	logic signed [DVW-1:0] f_den;
	logic [PW-1:0]         q_wdata, q_rdata;
	logic [1:0]            out_kind;
	logic [OW-1:0]         out_first, out_second;

	qrs_front #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.coef_a   ($signed(s_tdata[W-1:0])),
		.coef_b   ($signed(s_tdata[2*W-1:W])),
		.coef_c   ($signed(s_tdata[3*W-1:2*W])),
		.stat     (stat),
		.push     (push),
		.kind     (f_kind),
		.disc     (f_disc),
		.nb       (f_nb),
		.den      (f_den)
	);

	assign q_wdata = {f_kind, f_den, f_nb, f_disc};

	qrs_fifo #(.WIDTH(PW), .DEPTH(qrs_pkg::FIFO_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.pop    (pop),
		.rdata  (q_rdata),
		.stat   (stat)
	);

	qrs_back #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.stat       (stat),
		.pop        (pop),
		.kind_in    (q_rdata[PW-1 -: 2]),
		.disc_in    ($signed(q_rdata[DW-1:0])),
		.nb_in      ($signed(q_rdata[DW+NBW-1:DW])),
		.den_in     ($signed(q_rdata[DW+NBW+DVW-1:DW+NBW])),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (out_kind),
		.out_first  (out_first),
		.out_second (out_second)
	);

	assign m_tdata = MW'({out_second, out_first});
	assign m_tuser = {6'b0, out_kind};

endmodule
